/* design/nrps_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the release pool stack.
package nrps_pkg;

  // Store sizes
  localparam int HANDLE_DEPTH = 32;
  localparam int LEVEL_DEPTH  = 16;

  // Field widths
  localparam int FUNC_W   = 2;
  localparam int HANDLE_W = 32;
  localparam int LEVEL_W  = 4;
  localparam int STATUS_W = 2;

  // Derived widths: counts hold the depth itself, addresses index the stores
  localparam int CNT_W   = $clog2(HANDLE_DEPTH + 1);
  localparam int HADDR_W = $clog2(HANDLE_DEPTH);
  localparam int LVL_W   = $clog2(LEVEL_DEPTH + 1);
  localparam int LADDR_W = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
  localparam int LCMP_W  = (LVL_W > LEVEL_W) ? LVL_W : LEVEL_W;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_DEFER   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_RECLAIM = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_OPEN    = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_CLOSE   = 2'd3;

  // Completion status codes
  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_STACK_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NEST_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_STALE      = 2'd3;

  // Result word kinds
  localparam logic KIND_DONE    = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic capture;   // take the input word into the operand registers
    logic done;      // apply the operation and emit its completion word
    logic pop_top;   // pop the top handle and emit it as a release word
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic              is_close;  // captured operation is a close
    logic              stale;     // captured close level is not open
    logic              above;     // handle count still above the close mark
    logic              out_free;  // output register can take a word this cycle
  } sts_t;

endpackage

/* design/nrps_ctrl.sv */
// Controller state machine: sequences capture, execute and the close release walk.
module nrps_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          op_valid,
  output logic          op_stall,
  input  nrps_pkg::sts_t sts,
  output nrps_pkg::cmd_t cmd
);
  import nrps_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_WALK = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // Input side is open only while no operation is in flight
  assign op_stall = (state != ST_IDLE);

  // Next state and commands
  always_comb begin
    state_next  = state;
    cmd.capture = 1'b0;
    cmd.done    = 1'b0;
    cmd.pop_top = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (op_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts.is_close && !sts.stale) begin
          state_next = ST_WALK;
        end else if (sts.out_free) begin
          cmd.done   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_WALK: begin
        // one release word per cycle while the result register is free, then the completion
        if (sts.out_free) begin
          if (sts.above) begin
            cmd.pop_top = 1'b1;
          end else begin
            cmd.done   = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* design/nrps_dp.sv */
// Datapath: handle and mark stores, counters, operand registers and the result register.
module nrps_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [nrps_pkg::FUNC_W-1:0]    func,
  input  logic [nrps_pkg::HANDLE_W-1:0]  handle,
  input  logic [nrps_pkg::LEVEL_W-1:0]   level,
  input  nrps_pkg::cmd_t                 cmd,
  output nrps_pkg::sts_t                 sts,
  output logic                           res_valid,
  input  logic                           res_stall,
  output logic                           kind,
  output logic [nrps_pkg::HANDLE_W-1:0]  obj_handle,
  output logic [nrps_pkg::LEVEL_W-1:0]   level_out,
  output logic                           hit,
  output logic [nrps_pkg::STATUS_W-1:0]  status
  ,
  output logic                           last
);
  import nrps_pkg::*;

  // Stores
  logic [HANDLE_W-1:0] handle_mem [HANDLE_DEPTH];
  logic [CNT_W-1:0]    mark_mem   [LEVEL_DEPTH];

  // Operand registers
  logic [FUNC_W-1:0]   func_q;
  logic [HANDLE_W-1:0] handle_q;
  logic [LEVEL_W-1:0]  level_q;

  // Stack pointers
  logic [CNT_W-1:0]    handle_count;
  logic [LVL_W-1:0]    open_levels;

  // Registered read data
  logic [HANDLE_W-1:0] top_rd;
  logic [CNT_W-1:0]    mark_rd;

  logic [CNT_W-1:0]    top_addr_full;
  logic [HADDR_W-1:0]  top_addr;
  logic [LADDR_W-1:0]  mark_addr;
  logic                full;
  logic                nest_full;
  logic                top_hit;
  logic                stale;
  logic                do_push;
  logic                do_pop;
  logic                do_open;
  logic                emit;
  logic                out_free;

  // Operation decode against current state
  assign full      = (handle_count == CNT_W'(HANDLE_DEPTH));
  assign nest_full = (open_levels == LVL_W'(LEVEL_DEPTH));
  assign top_hit   = (handle_count != '0) && (top_rd == handle_q);
  assign stale     = (LCMP_W'(level_q) >= LCMP_W'(open_levels));

  assign do_push = cmd.done && (func_q == FUNC_DEFER) && (handle_q != '0) && !full;
  assign do_pop  = cmd.pop_top || (cmd.done && (func_q == FUNC_RECLAIM) && top_hit);
  assign do_open = cmd.done && (func_q == FUNC_OPEN) && !nest_full;

  // Top-of-stack read tracks the top entry, or the one below it while a release pops
  assign top_addr_full = handle_count - CNT_W'(cmd.pop_top ? 2 : 1);
  assign top_addr      = top_addr_full[HADDR_W-1:0];
  assign mark_addr     = cmd.capture ? LADDR_W'(level) : LADDR_W'(level_q);

  assign out_free = !res_valid || !res_stall;
  assign emit     = cmd.done || cmd.pop_top;

  assign sts.is_close = (func_q == FUNC_CLOSE);
  assign sts.stale    = stale;
  assign sts.above    = (handle_count > mark_rd);
  assign sts.out_free = out_free;

  // Handle store: one write, one registered read
  always_ff @(posedge clk) begin
    if (do_push) begin
      handle_mem[handle_count[HADDR_W-1:0]] <= handle_q;
    end
    top_rd <= handle_mem[top_addr];
  end

  // Mark store: one write, one registered read
  always_ff @(posedge clk) begin
    if (do_open) begin
      mark_mem[open_levels[LADDR_W-1:0]] <= handle_count;
    end
    mark_rd <= mark_mem[mark_addr];
  end

  // Operand capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_q   <= func;
      handle_q <= handle;
      level_q  <= level;
    end
  end

  // Stack pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      handle_count <= '0;
      open_levels  <= '0;
    end else begin
      if (do_push) begin
        handle_count <= handle_count + CNT_W'(1);
      end else if (do_pop) begin
        handle_count <= handle_count - CNT_W'(1);
      end
      if (do_open) begin
        open_levels <= open_levels + LVL_W'(1);
      end else if (cmd.done && (func_q == FUNC_CLOSE) && !stale) begin
        open_levels <= LVL_W'(level_q);
      end
    end
  end

  // Result word valid
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  // Result word payload
  always_ff @(posedge clk) begin
    if (cmd.pop_top) begin
      kind       <= KIND_RELEASE;
      obj_handle <= top_rd;
      level_out  <= '0;
      hit        <= 1'b0;
      status     <= STATUS_OK;
      last       <= 1'b0;
    end else if (cmd.done) begin
      kind       <= KIND_DONE;
      obj_handle <= '0;
      level_out  <= '0;
      hit        <= 1'b0;
      status     <= STATUS_OK;
      last       <= 1'b1;
      unique case (func_q)
        FUNC_DEFER: begin
          obj_handle <= handle_q;
          if ((handle_q != '0) && full) begin
            status <= STATUS_STACK_FULL;
          end
        end
        FUNC_RECLAIM: begin
          hit <= top_hit;
        end
        FUNC_OPEN: begin
          if (nest_full) begin
            status <= STATUS_NEST_FULL;
          end else begin
            level_out <= LEVEL_W'(open_levels);
          end
        end
        FUNC_CLOSE: begin
          if (stale) begin
            status <= STATUS_STALE;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

/* design/nested_release_pool_stack_core.sv */
// Top level of the release pool stack: controller plus datapath.
//
//   channel | valid      | stall      | word fields
//   --------+------------+------------+-------------------------------------------
//   op      | op_valid   | op_stall   | func, handle, level
//   res     | res_valid  | res_stall  | kind, obj_handle, level_out, hit, status, last
//
// One operation word at a time: the next is accepted only after the current one
// has emitted its completion word. A close releases its handles one release word
// per cycle when not stalled, paced by the registered read of the handle store.
// Reset clears the handle count, the open level count and the result valid.
// A stalled result word holds; the walk pauses until the result register frees.
module nested_release_pool_stack_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           op_valid,
  output logic                           op_stall,
  input  logic [nrps_pkg::FUNC_W-1:0]    func,
  input  logic [nrps_pkg::HANDLE_W-1:0]  handle,
  input  logic [nrps_pkg::LEVEL_W-1:0]   level,
  output logic                           res_valid,
  input  logic                           res_stall,
  output logic                           kind,
  output logic [nrps_pkg::HANDLE_W-1:0]  obj_handle,
  output logic [nrps_pkg::LEVEL_W-1:0]   level_out,
  output logic                           hit,
  output logic [nrps_pkg::STATUS_W-1:0]  status,
  output logic                           last
);
  import nrps_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  nrps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .op_valid (op_valid),
    .op_stall (op_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Stores, counters and result register
  nrps_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .func       (func),
    .handle     (handle),
    .level      (level),
    .cmd        (cmd),
    .sts        (sts),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .kind       (kind),
    .obj_handle (obj_handle),
    .level_out  (level_out),
    .hit        (hit),
    .status     (status),
    .last       (last)
  );

endmodule
